### design/clt_pkg.sv
`default_nettype none

package clt_pkg;

    localparam int LINE_CHARS = 64;
    localparam int MAX_FIELDS = 8;

    localparam int ADDR_W = $clog2(LINE_CHARS);
    localparam int CNT_W  = $clog2(LINE_CHARS + 1);
    localparam int FCNT_W = $clog2(MAX_FIELDS + 1);
    localparam int FIDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    localparam int IDX_OUT_W   = 3;
    localparam int START_OUT_W = 6;
    localparam int TOTAL_OUT_W = 4;
    localparam int LEN_OUT_W   = 7;
    localparam int FIELDS_W    = IDX_OUT_W + START_OUT_W + TOTAL_OUT_W + LEN_OUT_W;
    localparam int DATA_W      = ((FIELDS_W + 7) / 8) * 8;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_LZ    = 7'h7A;
    localparam logic [6:0] CH_D0    = 7'h30;
    localparam logic [6:0] CH_D9    = 7'h39;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CASE_BIT = 7'h20;

    typedef enum logic [1:0] {
        KIND_ALPHA   = 2'd0,
        KIND_NUMERIC = 2'd1,
        KIND_NONE    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              push;
        logic              clear;
        logic [ADDR_W-1:0] rd_addr;
    } edit_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
    } edit_stat_t;

endpackage

`default_nettype wire

### design/command_line_tokenizer.sv
// Line editor with field tokenizer.
// s_ channel: one received byte per request in s_tdata[7:0]. Printable codes
// are stored (capitals lowered), backspace drops the last character, other
// codes are ignored. s_tready stays high between lines, so edit bytes can
// follow back to back.
// A carriage return, or any byte while the line is full, ends the line.
// The block then walks the stored line through the single read port of the
// line store, one character per cycle. It then emits one descriptor per
// field (up to 8 fields), one per cycle when m_tready is high, the last one with
// m_tlast. A line without fields gives one descriptor of kind "none".
// m_ channel: tdata = field_index, field_start, field_total, line_length;
// tuser = field_kind; tlast marks the final descriptor.
// s_tready is low from the line end until the last descriptor is loaded
// into the output register; a stalled receiver holds the walk results.
// Reset (aresetn low, synchronous) empties the line and drops any pending
// descriptor. The store itself needs no clearing pass.
`default_nettype none

module command_line_tokenizer
    import clt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [2:0] field_index, [8:3] field_start,
                                              // [12:9] field_total, [19:13] line_length
    output logic [1:0]             m_tuser,   // [1:0] field_kind
    output logic                   m_tlast
);

    edit_ctrl_t ctrl;
    edit_stat_t stat;
    logic [6:0] rd_data;

    clt_line_edit u_edit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .rx_byte (s_tdata),
        .rd_data (rd_data),
        .stat    (stat)
    );

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [ADDR_W-1:0] eval_pos_reg, eval_pos_next;
    logic [FCNT_W-1:0] found_reg, found_next;
    logic              delim_reg, delim_next;
    logic [ADDR_W-1:0] starts_reg [MAX_FIELDS];
    logic [ADDR_W-1:0] starts_next [MAX_FIELDS];
    kind_t             kinds_reg [MAX_FIELDS];
    kind_t             kinds_next [MAX_FIELDS];
    logic [FCNT_W-1:0] emit_reg, emit_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [IDX_OUT_W-1:0]   o_idx_reg, o_idx_next;
    logic [START_OUT_W-1:0] o_start_reg, o_start_next;
    kind_t                  o_kind_reg, o_kind_next;
    logic [TOTAL_OUT_W-1:0] o_total_reg, o_total_next;
    logic [LEN_OUT_W-1:0]   o_len_reg, o_len_next;
    logic                   o_last_reg, o_last_next;

    logic accept, eol, issue, is_letter, is_num, desc_last;

    assign accept    = s_tvalid && s_tready;
    assign eol       = (s_tdata == CH_CR) || stat.full;
    assign is_letter = (rd_data >= CH_LA) && (rd_data <= CH_LZ);
    assign is_num    = ((rd_data >= CH_D0) && (rd_data <= CH_D9))
                       || (rd_data == CH_COMMA) || (rd_data == CH_DOT);
    assign issue     = (pos_reg < stat.count);
    assign desc_last = (found_reg == '0) || ((emit_reg + 1'b1) == found_reg);

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        eval_valid_next = 1'b0;
        eval_pos_next   = eval_pos_reg;
        found_next      = found_reg;
        delim_next      = delim_reg;
        starts_next     = starts_reg;
        kinds_next      = kinds_reg;
        emit_next       = emit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        o_idx_next      = o_idx_reg;
        o_start_next    = o_start_reg;
        o_kind_next     = o_kind_reg;
        o_total_next    = o_total_reg;
        o_len_next      = o_len_reg;
        o_last_next     = o_last_reg;
        s_tready        = 1'b0;
        ctrl.push       = 1'b0;
        ctrl.clear      = 1'b0;
        ctrl.rd_addr    = pos_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                ctrl.push = accept && !eol;
                if (accept && eol) begin
                    state_next = S_WALK;
                    pos_next   = '0;
                    found_next = '0;
                    delim_next = 1'b1;
                end
            end
            S_WALK: begin
                eval_valid_next = issue;
                eval_pos_next   = pos_reg[ADDR_W-1:0];
                if (issue) begin
                    pos_next = pos_reg + 1'b1;
                end
                if (eval_valid_reg) begin
                    if (is_letter || is_num) begin
                        if (delim_reg && (found_reg < FCNT_W'(MAX_FIELDS))) begin
                            starts_next[found_reg[FIDX_W-1:0]] = eval_pos_reg;
                            kinds_next[found_reg[FIDX_W-1:0]]  =
                                is_letter ? KIND_ALPHA : KIND_NUMERIC;
                            found_next = found_reg + 1'b1;
                        end
                        delim_next = 1'b0;
                    end else begin
                        delim_next = 1'b1;
                    end
                end
                if (!issue && !eval_valid_reg) begin
                    state_next = S_EMIT;
                    emit_next  = '0;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    o_len_next    = LEN_OUT_W'(stat.count);
                    o_last_next   = desc_last;
                    if (found_reg == '0) begin
                        o_idx_next   = '0;
                        o_start_next = '0;
                        o_kind_next  = KIND_NONE;
                        o_total_next = '0;
                    end else begin
                        o_idx_next   = IDX_OUT_W'(emit_reg);
                        o_start_next = START_OUT_W'(starts_reg[emit_reg[FIDX_W-1:0]]);
                        o_kind_next  = kinds_reg[emit_reg[FIDX_W-1:0]];
                        o_total_next = TOTAL_OUT_W'(found_reg);
                    end
                    if (desc_last) begin
                        ctrl.clear = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            eval_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        eval_pos_reg <= eval_pos_next;
        found_reg    <= found_next;
        delim_reg    <= delim_next;
        starts_reg   <= starts_next;
        kinds_reg    <= kinds_next;
        emit_reg     <= emit_next;
        o_idx_reg    <= o_idx_next;
        o_start_reg  <= o_start_next;
        o_kind_reg   <= o_kind_next;
        o_total_reg  <= o_total_next;
        o_len_reg    <= o_len_next;
        o_last_reg   <= o_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(DATA_W - FIELDS_W)'(0), o_len_reg, o_total_reg, o_start_reg, o_idx_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

### design/clt_line_edit.sv
`default_nettype none

module clt_line_edit
    import clt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire edit_ctrl_t ctrl,
    input  wire logic [7:0] rx_byte,
    output logic [6:0]      rd_data,
    output edit_stat_t      stat
);

    logic [6:0]       mem [LINE_CHARS];
    logic [6:0]       rd_data_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic [6:0]       wr_char;
    logic             full;

    assign full = (count_reg == CNT_W'(LINE_CHARS));

    always_comb begin
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_char    = rx_byte[6:0];
        if ((rx_byte >= CH_UA) && (rx_byte <= CH_UZ)) begin
            wr_char = rx_byte[6:0] | CASE_BIT;
        end
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.push && !full) begin
            if ((rx_byte == CH_BS) || (rx_byte == CH_DEL)) begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end
            end else if ((rx_byte >= CH_SPACE) && (rx_byte < CH_DEL)) begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= wr_char;
        end
        rd_data_reg <= mem[ctrl.rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign stat.count = count_reg;
    assign stat.full  = full;

endmodule

`default_nettype wire

### design/clt_checker.sv
`default_nettype none

module clt_checker
    import clt_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [1:0]        m_tuser,
    input wire logic              m_tlast
);

    // stalled request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled descriptor changed");

    // no-field descriptor is alone and carries a zero total
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_NONE) |-> m_tlast && (m_tdata[12:9] == '0)
        && (m_tdata[8:0] == '0))
        else $error("bad empty-line descriptor");

    // input stays closed while a line is still being emitted
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open mid-line");

    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("descriptor run broken");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
